// File: rtl/core/usm_pkg.sv
// ----------------------------------------------------------------------------
// usm_pkg
// Shared widths, register codes and pipeline control types for the 3x3
// unsharp mask block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package usm_pkg;

	localparam int PIX_W    = 8;
	localparam int CNT_W    = 9;
	localparam int GAIN_W   = 10;
	localparam int CSUM_W   = 10;
	localparam int SUM_W    = 12;
	localparam int PROD_W   = 18;
	localparam int APB_AW   = 4;
	localparam int RND_HALF = 128;

	typedef enum logic [1:0] {
		REG_FRAME_WIDTH   = 2'd0,
		REG_FRAME_HEIGHT  = 2'd1,
		REG_GAIN_ORIGINAL = 2'd2,
		REG_GAIN_BLURRED  = 2'd3
	} usm_reg_t;

	localparam logic [CNT_W-1:0]  FRAME_WIDTH_RST   = 9'd256;
	localparam logic [CNT_W-1:0]  FRAME_HEIGHT_RST  = 9'd256;
	localparam logic [GAIN_W-1:0] GAIN_ORIGINAL_RST = 10'd448;
	localparam logic [GAIN_W-1:0] GAIN_BLURRED_RST  = 10'd192;

	// Which results an item produces: emit_a is the pixel left of the
	// current column, emit_b the right-edge pixel at the end of a row.
	typedef struct packed {
		logic emit_a;
		logic emit_b;
		logic frame_end;
	} usm_emit_t;

	typedef struct packed {
		usm_emit_t        emit;
		logic             row_ge1;
		logic             row_ge2;
		logic             draining;
		logic             col_first;
		logic [CNT_W-1:0] col;
	} usm_ctl_t;

endpackage

`default_nettype wire

// File: rtl/core/usm_line_buf.sv
// ----------------------------------------------------------------------------
// usm_line_buf
// Two-row line store in one synchronous memory, with read-modify-write of
// each column entry and a bypass for back-to-back accesses to one column.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module usm_line_buf import usm_pkg::*; #(
	parameter int MAX_WIDTH = 256
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             rd_valid,
	input  wire usm_ctl_t         rd_ctl,
	input  wire logic [PIX_W-1:0] rd_pixel,
	output logic                  valid_s1,
	output usm_ctl_t              ctl_s1,
	output logic [PIX_W-1:0]      top,
	output logic [PIX_W-1:0]      mid,
	output logic [PIX_W-1:0]      pix
);

	localparam int AW    = $clog2(MAX_WIDTH);
	localparam int ENT_W = 2 * PIX_W;

	// Each entry holds {older row, newer row} for one column.
	logic [ENT_W-1:0] mem_q [MAX_WIDTH];
	logic [ENT_W-1:0] rd_data_s1;
	logic [ENT_W-1:0] byp_data_s1;
	logic [ENT_W-1:0] entry;
	logic [ENT_W-1:0] wr_data;
	logic             byp_s1;
	logic [PIX_W-1:0] pixel_s1;
	logic [PIX_W-1:0] older;
	logic [PIX_W-1:0] newer;
	logic [AW-1:0]    rd_addr;
	logic [AW-1:0]    wr_addr;

	assign rd_addr = AW'(rd_ctl.col);
	assign wr_addr = AW'(ctl_s1.col);

	// The memory returns the old entry when the item just ahead wrote the
	// same column in the read cycle, so its write data is taken instead.
	assign entry = byp_s1 ? byp_data_s1 : rd_data_s1;
	assign older = entry[ENT_W-1:PIX_W];
	assign newer = entry[PIX_W-1:0];

	assign mid     = newer;
	assign top     = ctl_s1.row_ge2 ? older : newer;
	assign pix     = ctl_s1.draining ? newer : pixel_s1;
	assign wr_data = {newer, pix};

	always_ff @(posedge clk) begin
		if (rd_valid) begin
			rd_data_s1 <= mem_q[rd_addr];
		end
		if (valid_s1) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			byp_s1   <= 1'b0;
		end else begin
			valid_s1 <= rd_valid;
			byp_s1   <= rd_valid & valid_s1 & (rd_ctl.col == ctl_s1.col);
		end
	end

	always_ff @(posedge clk) begin
		ctl_s1      <= rd_ctl;
		pixel_s1    <= rd_pixel;
		byp_data_s1 <= wr_data;
	end

endmodule

`default_nettype wire

// File: rtl/core/usm_window.sv
// ----------------------------------------------------------------------------
// usm_window
// 3x3 window kept as three column sums and three centre pixels, with edge
// replication at the first column and the 1-2-1 blur sums for both outputs.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module usm_window import usm_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             valid_s1,
	input  wire usm_ctl_t         ctl_s1,
	input  wire logic [PIX_W-1:0] top,
	input  wire logic [PIX_W-1:0] mid,
	input  wire logic [PIX_W-1:0] pix,
	output logic                  valid_s2,
	output usm_emit_t             emit_s2,
	output logic [SUM_W-1:0]      sum_a_s2,
	output logic [SUM_W-1:0]      sum_b_s2,
	output logic [PIX_W-1:0]      cen_a_s2,
	output logic [PIX_W-1:0]      cen_b_s2
);

	logic [CSUM_W-1:0] cs_q [3];
	logic [PIX_W-1:0]  md_q [3];
	logic [CSUM_W-1:0] cs_n [3];
	logic [PIX_W-1:0]  md_n [3];
	logic [CSUM_W-1:0] new_cs;
	logic [SUM_W-1:0]  sum_a;
	logic [SUM_W-1:0]  sum_b;
	logic              upd;

	assign upd    = valid_s1 & ctl_s1.row_ge1;
	assign new_cs = CSUM_W'(top) + CSUM_W'({mid, 1'b0}) + CSUM_W'(pix);

	// At the first column all three window columns take the new column,
	// which replicates the left border.
	always_comb begin
		cs_n[0] = ctl_s1.col_first ? new_cs : cs_q[1];
		cs_n[1] = ctl_s1.col_first ? new_cs : cs_q[2];
		cs_n[2] = new_cs;
		md_n[0] = ctl_s1.col_first ? mid : md_q[1];
		md_n[1] = ctl_s1.col_first ? mid : md_q[2];
		md_n[2] = mid;
	end

	// The right-edge output repeats the last column in place of a right one.
	assign sum_a = SUM_W'(cs_n[0]) + SUM_W'({cs_n[1], 1'b0}) + SUM_W'(cs_n[2]);
	assign sum_b = SUM_W'(cs_n[1]) + SUM_W'({cs_n[2], 1'b0}) + SUM_W'(cs_n[2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 3; i++) begin
				cs_q[i] <= '0;
				md_q[i] <= '0;
			end
			valid_s2 <= 1'b0;
		end else begin
			if (upd) begin
				for (int i = 0; i < 3; i++) begin
					cs_q[i] <= cs_n[i];
					md_q[i] <= md_n[i];
				end
			end
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		emit_s2  <= ctl_s1.emit;
		sum_a_s2 <= sum_a;
		sum_b_s2 <= sum_b;
		cen_a_s2 <= md_n[1];
		cen_b_s2 <= md_n[2];
	end

endmodule

`default_nettype wire

// File: rtl/core/usm_crispen.sv
// ----------------------------------------------------------------------------
// usm_crispen
// Rounds the blur, weights centre and blur by the Q8 gains, and saturates
// the difference to an 8-bit pixel for both result lanes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module usm_crispen import usm_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic [GAIN_W-1:0] gain_original,
	input  wire logic [GAIN_W-1:0] gain_blurred,
	input  wire logic              valid_s2,
	input  wire usm_emit_t         emit_s2,
	input  wire logic [SUM_W-1:0]  sum_a_s2,
	input  wire logic [SUM_W-1:0]  sum_b_s2,
	input  wire logic [PIX_W-1:0]  cen_a_s2,
	input  wire logic [PIX_W-1:0]  cen_b_s2,
	output logic                   valid_s3,
	output usm_emit_t              emit_s3,
	output logic [PIX_W-1:0]       res_a,
	output logic [PIX_W-1:0]       res_b
);

	logic [SUM_W-1:0]  rnd_a;
	logic [SUM_W-1:0]  rnd_b;
	logic [PIX_W-1:0]  blur_a;
	logic [PIX_W-1:0]  blur_b;
	logic [PROD_W-1:0] pf_a_s3;
	logic [PROD_W-1:0] pl_a_s3;
	logic [PROD_W-1:0] pf_b_s3;
	logic [PROD_W-1:0] pl_b_s3;

	function automatic logic [PIX_W-1:0] saturate(
		input logic [PROD_W-1:0] pf,
		input logic [PROD_W-1:0] pl
	);
		logic [PROD_W+1:0] d;
		d = {2'b00, pf} - {2'b00, pl} + (PROD_W+2)'(RND_HALF);
		if (d[PROD_W+1]) begin
			saturate = '0;
		end else if (d[PROD_W:2*PIX_W] != '0) begin
			saturate = '1;
		end else begin
			saturate = d[2*PIX_W-1:PIX_W];
		end
	endfunction

	// Blur divides the 16-weight sum with rounding half up.
	assign rnd_a  = sum_a_s2 + SUM_W'(8);
	assign rnd_b  = sum_b_s2 + SUM_W'(8);
	assign blur_a = rnd_a[SUM_W-1:4];
	assign blur_b = rnd_b[SUM_W-1:4];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		emit_s3 <= emit_s2;
		pf_a_s3 <= PROD_W'(gain_original) * PROD_W'(cen_a_s2);
		pl_a_s3 <= PROD_W'(gain_blurred) * PROD_W'(blur_a);
		pf_b_s3 <= PROD_W'(gain_original) * PROD_W'(cen_b_s2);
		pl_b_s3 <= PROD_W'(gain_blurred) * PROD_W'(blur_b);
	end

	assign res_a = saturate(pf_a_s3, pl_a_s3);
	assign res_b = saturate(pf_b_s3, pl_b_s3);

endmodule

`default_nettype wire

// File: rtl/core/usm_out_fifo.sv
// ----------------------------------------------------------------------------
// usm_out_fifo
// Result queue that takes up to two results per cycle and hands out one
// beat per cycle while m_axis_tready is high; it grants input only while
// room is reserved for every item in flight.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module usm_out_fifo import usm_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push_valid,
	input  wire usm_emit_t        emit,
	input  wire logic [PIX_W-1:0] res_a,
	input  wire logic [PIX_W-1:0] res_b,
	input  wire logic [1:0]       busy,
	output logic                  in_ready,
	output logic                  m_axis_tvalid,
	input  wire logic             m_axis_tready,
	output logic [PIX_W-1:0]      m_axis_tdata,
	output logic                  m_axis_tlast,
	output logic                  m_axis_tuser
);

	localparam int DEPTH = 16;
	localparam int PW    = $clog2(DEPTH);
	localparam int CW    = $clog2(DEPTH + 1);

	typedef struct packed {
		logic             frame_last;
		logic             row_last;
		logic [PIX_W-1:0] pixel;
	} res_entry_t;

	res_entry_t     fifo_q [DEPTH];
	logic [PW-1:0]  wr_ptr_q;
	logic [PW-1:0]  rd_ptr_q;
	logic [CW-1:0]  count_q;
	logic [PW-1:0]  b_ptr;
	logic           push_a;
	logic           push_b;
	logic           pop;
	logic [1:0]     n_push;
	logic [CW:0]    reserve;
	res_entry_t     head;

	assign push_a = push_valid & emit.emit_a;
	assign push_b = push_valid & emit.emit_b;
	assign n_push = {1'b0, push_a} + {1'b0, push_b};
	assign b_ptr  = wr_ptr_q + PW'(push_a);
	assign pop    = m_axis_tvalid & m_axis_tready;

	// Every item in the pipeline may still bring two results.
	assign reserve  = (CW+1)'(count_q) + (CW+1)'({busy, 1'b0});
	assign in_ready = reserve <= (CW+1)'(DEPTH - 2);

	assign head          = fifo_q[rd_ptr_q];
	assign m_axis_tvalid = count_q != '0;
	assign m_axis_tdata  = head.pixel;
	assign m_axis_tlast  = head.row_last;
	assign m_axis_tuser  = head.frame_last;

	always_ff @(posedge clk) begin
		if (push_a) begin
			fifo_q[wr_ptr_q] <= '{frame_last: 1'b0, row_last: 1'b0, pixel: res_a};
		end
		if (push_b) begin
			fifo_q[b_ptr] <= '{frame_last: emit.frame_end, row_last: 1'b1, pixel: res_b};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + PW'(n_push);
			rd_ptr_q <= rd_ptr_q + PW'(pop);
			count_q  <= count_q + CW'(n_push) - CW'(pop);
		end
	end

`ifndef SYNTH
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("result queue holds more entries than its depth");

	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		(n_push != 2'd0) |-> ((CW+1)'(count_q) + (CW+1)'(n_push) <= (CW+1)'(DEPTH)))
		else $error("result pushed without reserved room");

	a_frame_end_row: assert property (@(posedge clk) disable iff (!arst_n)
		(push_valid && emit.frame_end) |-> emit.emit_b)
		else $error("frame end flagged on a result that does not close a row");
`endif

endmodule

`default_nettype wire

// File: rtl/core/unsharp_mask_3x3_crispen.sv
// ----------------------------------------------------------------------------
// unsharp_mask_3x3_crispen
// Streaming 3x3 unsharp mask for 8-bit grey pixels with edge replication.
// ----------------------------------------------------------------------------
// Pixels enter on s_axis in raster order, one beat per clock when the block
// is ready; s_axis_tuser marks a flush beat. After the last row of a frame a
// row of beats drains the bottom output row (any beat counts as flush then);
// flush beats before that are taken and dropped.
// Results leave on m_axis: tlast marks the end of an output row and tuser
// the last pixel of the frame. Output trails input by one row and one pixel.
// The pipeline is four stages: counters and line store read, window update
// and blur sums, gain products, then saturation into a 16-entry result
// queue. Results pass the line store, window and product registers, then the
// queue. Sustained rate is one input beat per clock while m_axis keeps up; a
// beat that closes a row yields two results and the queue evens them out over
// the following cycles. When m_axis stalls the queue fills; s_axis_tready
// drops while the queue could not take two results from every beat in flight.
// Reset clears counters, window, pipeline and queue and restores register
// defaults. The line stores are not cleared: each entry is written in the
// first row before it is used. The user must write registers over APB only
// while no beat is in flight; the block itself does not enforce it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module unsharp_mask_3x3_crispen import usm_pkg::*; #(
	parameter int MAX_WIDTH = 256
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [APB_AW-1:0] paddr,
	input  wire logic [31:0]       pwdata,
	output logic [31:0]            prdata,
	output logic                   pready,
	input  wire logic              s_axis_tvalid,
	output logic                   s_axis_tready,
	input  wire logic [PIX_W-1:0]  s_axis_tdata,  // [7:0] pixel_in
	input  wire logic              s_axis_tuser,  // [0] is_flush
	output logic                   m_axis_tvalid,
	input  wire logic              m_axis_tready,
	output logic [PIX_W-1:0]       m_axis_tdata,  // [7:0] pixel_out
	output logic                   m_axis_tlast,
	output logic                   m_axis_tuser   // [0] frame_last
);

	localparam int               CAP  = (MAX_WIDTH > 511) ? 511 : MAX_WIDTH;
	localparam logic [CNT_W-1:0] WCAP = CNT_W'(CAP);

	logic [CNT_W-1:0]  frame_width_q;
	logic [CNT_W-1:0]  frame_height_q;
	logic [GAIN_W-1:0] gain_original_q;
	logic [GAIN_W-1:0] gain_blurred_q;
	logic [CNT_W-1:0]  col_q;
	logic [CNT_W-1:0]  row_q;

	logic [CNT_W-1:0]  w_eff;
	logic [CNT_W-1:0]  w_last;
	logic [CNT_W-1:0]  h_eff;
	logic [CNT_W-1:0]  c_cur;
	logic [CNT_W-1:0]  r_cur;
	logic              draining;
	logic              last_col;
	logic              in_acc;
	logic              issue;
	logic              cfg_wr;
	usm_reg_t          reg_sel;
	usm_ctl_t          ctl_s0;

	logic              valid_s1;
	usm_ctl_t          ctl_s1;
	logic [PIX_W-1:0]  top_s1;
	logic [PIX_W-1:0]  mid_s1;
	logic [PIX_W-1:0]  pix_s1;
	logic              valid_s2;
	usm_emit_t         emit_s2;
	logic [SUM_W-1:0]  sum_a_s2;
	logic [SUM_W-1:0]  sum_b_s2;
	logic [PIX_W-1:0]  cen_a_s2;
	logic [PIX_W-1:0]  cen_b_s2;
	logic              valid_s3;
	usm_emit_t         emit_s3;
	logic [PIX_W-1:0]  res_a;
	logic [PIX_W-1:0]  res_b;
	logic [1:0]        busy;

	// Configuration port
	assign pready  = 1'b1;
	assign cfg_wr  = psel & penable & pwrite;
	assign reg_sel = usm_reg_t'(paddr[APB_AW-1:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q   <= FRAME_WIDTH_RST;
			frame_height_q  <= FRAME_HEIGHT_RST;
			gain_original_q <= GAIN_ORIGINAL_RST;
			gain_blurred_q  <= GAIN_BLURRED_RST;
		end else if (cfg_wr) begin
			case (reg_sel)
				REG_FRAME_WIDTH:   frame_width_q   <= pwdata[CNT_W-1:0];
				REG_FRAME_HEIGHT:  frame_height_q  <= pwdata[CNT_W-1:0];
				REG_GAIN_ORIGINAL: gain_original_q <= pwdata[GAIN_W-1:0];
				REG_GAIN_BLURRED:  gain_blurred_q  <= pwdata[GAIN_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (reg_sel)
			REG_FRAME_WIDTH:   prdata = 32'(frame_width_q);
			REG_FRAME_HEIGHT:  prdata = 32'(frame_height_q);
			REG_GAIN_ORIGINAL: prdata = 32'(gain_original_q);
			REG_GAIN_BLURRED:  prdata = 32'(gain_blurred_q);
			default:           prdata = '0;
		endcase
	end

	// Frame geometry; zero sizes act as one and counters past a shrunk
	// size act as the last column or the drain row.
	assign w_eff    = (frame_width_q == '0) ? CNT_W'(1)
	                : ((frame_width_q > WCAP) ? WCAP : frame_width_q);
	assign w_last   = w_eff - CNT_W'(1);
	assign h_eff    = (frame_height_q == '0) ? CNT_W'(1) : frame_height_q;
	assign c_cur    = (col_q > w_last) ? w_last : col_q;
	assign r_cur    = (row_q > h_eff) ? h_eff : row_q;
	assign draining = r_cur == h_eff;
	assign last_col = c_cur == w_last;

	assign in_acc = s_axis_tvalid & s_axis_tready;
	assign issue  = in_acc & (draining | ~s_axis_tuser);

	always_comb begin
		ctl_s0.row_ge1        = r_cur != '0;
		ctl_s0.row_ge2        = r_cur > CNT_W'(1);
		ctl_s0.draining       = draining;
		ctl_s0.col_first      = c_cur == '0;
		ctl_s0.col            = c_cur;
		ctl_s0.emit.emit_a    = ctl_s0.row_ge1 & ~ctl_s0.col_first;
		ctl_s0.emit.emit_b    = ctl_s0.row_ge1 & last_col;
		ctl_s0.emit.frame_end = ctl_s0.row_ge1 & last_col & draining;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (issue) begin
			if (last_col) begin
				col_q <= '0;
				row_q <= draining ? '0 : r_cur + CNT_W'(1);
			end else begin
				col_q <= c_cur + CNT_W'(1);
				row_q <= r_cur;
			end
		end
	end

	usm_line_buf #(
		.MAX_WIDTH(MAX_WIDTH)
	) u_line_buf (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_valid (issue),
		.rd_ctl   (ctl_s0),
		.rd_pixel (s_axis_tdata),
		.valid_s1 (valid_s1),
		.ctl_s1   (ctl_s1),
		.top      (top_s1),
		.mid      (mid_s1),
		.pix      (pix_s1)
	);

	usm_window u_window (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s1 (valid_s1),
		.ctl_s1   (ctl_s1),
		.top      (top_s1),
		.mid      (mid_s1),
		.pix      (pix_s1),
		.valid_s2 (valid_s2),
		.emit_s2  (emit_s2),
		.sum_a_s2 (sum_a_s2),
		.sum_b_s2 (sum_b_s2),
		.cen_a_s2 (cen_a_s2),
		.cen_b_s2 (cen_b_s2)
	);

	usm_crispen u_crispen (
		.clk           (clk),
		.arst_n        (arst_n),
		.gain_original (gain_original_q),
		.gain_blurred  (gain_blurred_q),
		.valid_s2      (valid_s2),
		.emit_s2       (emit_s2),
		.sum_a_s2      (sum_a_s2),
		.sum_b_s2      (sum_b_s2),
		.cen_a_s2      (cen_a_s2),
		.cen_b_s2      (cen_b_s2),
		.valid_s3      (valid_s3),
		.emit_s3       (emit_s3),
		.res_a         (res_a),
		.res_b         (res_b)
	);

	assign busy = {1'b0, valid_s1} + {1'b0, valid_s2} + {1'b0, valid_s3};

	usm_out_fifo u_out_fifo (
		.clk           (clk),
		.arst_n        (arst_n),
		.push_valid    (valid_s3),
		.emit          (emit_s3),
		.res_a         (res_a),
		.res_b         (res_b),
		.busy          (busy),
		.in_ready      (s_axis_tready),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.m_axis_tuser  (m_axis_tuser)
	);

endmodule

`default_nettype wire

// File: dv/unsharp_mask_3x3_crispen_tb.sv
// ----------------------------------------------------------------------------
// unsharp_mask_3x3_crispen_tb
// Self-checking testbench for the streaming 3x3 unsharp mask block.
// ----------------------------------------------------------------------------
// Pixel beats are sent on s_axis with random gaps. Each accepted beat goes
// through a behavioral copy of the window, line stores and crispening math,
// which queues the output pixels it should cause. A checker pops one
// expectation per m_axis beat and compares all fields, while m_axis_tready
// stalls at random. Registers are written over APB only while nothing is in
// flight, and each write is read back.
// The tests cover reset defaults, counters left past a shrunk width or
// height, the smallest and zero sizes, gain extremes that saturate and
// clamp, and then random frames with noise beats and a few extreme sizes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module unsharp_mask_3x3_crispen_tb;
	import usm_pkg::*;

	localparam int MAX_W        = 256;
	localparam int CYCLE_LIMIT  = 1_000_000;
	localparam int SETTLE_TICKS = 12;
	localparam int RANDOM_ITEMS = 2000;

	typedef struct packed {
		logic [PIX_W-1:0] pix;
		logic             row_end;
		logic             frame_end;
	} crisp_pix_t;

	logic              clk           = 1'b0;
	logic              arst_n        = 1'b0;
	logic              psel          = 1'b0;
	logic              penable       = 1'b0;
	logic              pwrite        = 1'b0;
	logic [APB_AW-1:0] paddr         = '0;
	logic [31:0]       pwdata        = '0;
	logic [31:0]       prdata;
	logic              pready;
	logic              s_axis_tvalid = 1'b0;
	logic              s_axis_tready;
	logic [PIX_W-1:0]  s_axis_tdata  = '0; // [7:0] pixel_in
	logic              s_axis_tuser  = 1'b0; // [0] is_flush
	logic              m_axis_tvalid;
	logic              m_axis_tready = 1'b0;
	logic [PIX_W-1:0]  m_axis_tdata; // [7:0] pixel_out
	logic              m_axis_tlast;
	logic              m_axis_tuser; // [0] frame_last

	// Behavioral state of the block.
	logic [PIX_W-1:0] line_newer [MAX_W];
	logic [PIX_W-1:0] line_older [MAX_W];
	logic [PIX_W-1:0] win [9];
	int               col_cnt    = 0;
	int               row_cnt    = 0;
	int               cfg_w      = 256;
	int               cfg_h      = 256;
	int               gain_o     = 448;
	int               gain_b     = 192;

	crisp_pix_t crisp_q [$];
	int         err_count  = 0;
	int         item_count = 0;
	int         stall_left = 0;
	int         cycles     = 0;
	bit         steady     = 1'b0;

	unsharp_mask_3x3_crispen i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.m_axis_tuser  (m_axis_tuser)
	);

	always #4 clk = ~clk;

	task automatic report_mismatch(input string what, input int want, input int got);
		if (err_count < 100) begin
			$display("MISMATCH %s: expected %0d, got %0d at %0t", what, want, got, $time);
		end
		err_count++;
	endtask

	function automatic int pick_gap();
		int roll;
		if (steady) return 0;
		roll = $urandom_range(0, 99);
		if (roll < 60) return 0;
		if (roll < 92) return $urandom_range(1, 3);
		return $urandom_range(5, 30);
	endfunction

	function automatic logic [PIX_W-1:0] pick_pixel();
		int               roll;
		logic [PIX_W-1:0] v;
		roll = $urandom_range(0, 99);
		v = PIX_W'($urandom_range(0, 255));
		if (roll < 10) v = '0;
		else if (roll < 20) v = '1;
		return v;
	endfunction

	function automatic int col_sum(input int k);
		return int'(win[3*k]) + 2 * int'(win[3*k+1]) + int'(win[3*k+2]);
	endfunction

	function automatic logic [PIX_W-1:0] crispen_pixel(input int lc, input int cc, input int rc);
		int blur;
		int v;
		blur = (col_sum(lc) + 2 * col_sum(cc) + col_sum(rc) + 8) >>> 4;
		v = gain_o * int'(win[3*cc+1]) - gain_b * blur + RND_HALF;
		if (v < 0) return '0;
		v = v >>> 8;
		if (v > 255) return '1;
		return v[PIX_W-1:0];
	endfunction

	function automatic int eff_width();
		if (cfg_w == 0) return 1;
		if (cfg_w > MAX_W) return MAX_W;
		return cfg_w;
	endfunction

	function automatic int eff_height();
		return (cfg_h == 0) ? 1 : cfg_h;
	endfunction

	// Advances the window and line stores by one beat and queues the pixels it
	// completes: the one left of the column, and the right edge at row end.
	task automatic crispen_predict(input logic [PIX_W-1:0] pix, input logic flush,
			output bit taken);
		int         w;
		int         h;
		int         c;
		int         r;
		int         top;
		int         mid;
		int         p;
		int         k;
		bit         draining;
		bit         last_col;
		crisp_pix_t e;
		w = eff_width();
		h = eff_height();
		c = (col_cnt < w) ? col_cnt : w - 1;
		r = (row_cnt < h) ? row_cnt : h;
		draining = (r == h);
		last_col = (c == w - 1);
		taken = draining || !flush;
		if (taken) begin
			p = draining ? int'(line_newer[c]) : int'(pix);
			if (r >= 1) begin
				mid = int'(line_newer[c]);
				top = (r >= 2) ? int'(line_older[c]) : mid;
				if (c == 0) begin
					for (k = 0; k < 3; k++) begin
						win[3*k]   = PIX_W'(top);
						win[3*k+1] = PIX_W'(mid);
						win[3*k+2] = PIX_W'(p);
					end
				end else begin
					for (k = 0; k < 6; k++) win[k] = win[k+3];
					win[6] = PIX_W'(top);
					win[7] = PIX_W'(mid);
					win[8] = PIX_W'(p);
				end
				if (c >= 1) begin
					e.pix = crispen_pixel(0, 1, 2);
					e.row_end = 1'b0;
					e.frame_end = 1'b0;
					crisp_q.push_back(e);
				end
				if (last_col) begin
					e.pix = crispen_pixel(1, 2, 2);
					e.row_end = 1'b1;
					e.frame_end = draining;
					crisp_q.push_back(e);
				end
			end
			line_older[c] = line_newer[c];
			line_newer[c] = PIX_W'(p);
			if (last_col) begin
				col_cnt = 0;
				row_cnt = draining ? 0 : r + 1;
			end else begin
				col_cnt = c + 1;
				row_cnt = r;
			end
		end
	endtask

	task automatic apb_access(input logic wr, input usm_reg_t idx, input logic [31:0] wdata,
			output logic [31:0] rdata);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= {idx, 2'b00};
		pwdata  <= wdata;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		rdata = prdata;
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	task automatic check_reg(input usm_reg_t idx, input logic [31:0] want);
		logic [31:0] rd;
		apb_access(1'b0, idx, '0, rd);
		if (rd !== want) report_mismatch($sformatf("readback of %s", idx.name()), want, rd);
	endtask

	task automatic set_reg(input usm_reg_t idx, input logic [31:0] value);
		logic [31:0] rd;
		logic [31:0] masked;
		masked = (idx == REG_FRAME_WIDTH || idx == REG_FRAME_HEIGHT) ?
			(value & 32'h1FF) : (value & 32'h3FF);
		apb_access(1'b1, idx, masked, rd);
		case (idx)
			REG_FRAME_WIDTH: begin
				cfg_w = int'(masked);
			end
			REG_FRAME_HEIGHT: begin
				cfg_h = int'(masked);
			end
			REG_GAIN_ORIGINAL: begin
				gain_o = int'(masked);
			end
			default: begin
				gain_b = int'(masked);
			end
		endcase
		check_reg(idx, masked);
	endtask

	task automatic send_item(input logic [PIX_W-1:0] pix, input logic flush);
		int gap;
		bit taken;
		@(negedge clk);
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= pix;
		s_axis_tuser  <= flush;
		do @(posedge clk); while (!s_axis_tready);
		crispen_predict(pix, flush, taken);
		if (taken) item_count++;
		gap = pick_gap();
		if (gap > 0) begin
			@(negedge clk);
			s_axis_tvalid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
	endtask

	// Beats that cause no result may still be in the pipeline when the last
	// expected pixel arrives, so a further settling wait follows before returning.
	task automatic wait_idle();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (crisp_q.size() != 0) @(posedge clk);
		repeat (SETTLE_TICKS) @(posedge clk);
	endtask

	// One whole frame at the current size, with stray flush beats mixed into
	// the pixel rows and a drain row of mixed flush and pixel beats.
	task automatic send_frame(input int noise_pct);
		int w;
		int h;
		int r;
		int c;
		w = eff_width();
		h = eff_height();
		for (r = 0; r < h; r++) begin
			for (c = 0; c < w; c++) begin
				if ($urandom_range(0, 99) < noise_pct) send_item(pick_pixel(), 1'b1);
				send_item(pick_pixel(), 1'b0);
			end
		end
		for (c = 0; c < w; c++) send_item(pick_pixel(), $urandom_range(0, 99) < 70);
	endtask

	task automatic test_defaults_and_shrink();
		check_reg(REG_FRAME_WIDTH, 32'(FRAME_WIDTH_RST));
		check_reg(REG_FRAME_HEIGHT, 32'(FRAME_HEIGHT_RST));
		check_reg(REG_GAIN_ORIGINAL, 32'(GAIN_ORIGINAL_RST));
		check_reg(REG_GAIN_BLURRED, 32'(GAIN_BLURRED_RST));
		repeat (5) send_item(pick_pixel(), 1'b0);
		// The column count now lies past the new width, so the next beat
		// closes row 0.
		wait_idle();
		set_reg(REG_FRAME_WIDTH, 3);
		send_item(pick_pixel(), 1'b0);
		repeat (4) send_item(pick_pixel(), 1'b0);
		send_item(8'hA5, 1'b1);
		repeat (5) send_item(pick_pixel(), 1'b0);
		// Four rows are in; a height of two turns the next row into the drain.
		wait_idle();
		set_reg(REG_FRAME_HEIGHT, 2);
		send_item(8'h00, 1'b0);
		send_item(8'hFF, 1'b1);
		send_item(8'h7E, 1'b0);
	endtask

	task automatic test_corner_sizes();
		wait_idle();
		set_reg(REG_FRAME_WIDTH, 0);
		set_reg(REG_FRAME_HEIGHT, 0);
		send_item(8'hFF, 1'b0);
		send_item(8'h00, 1'b0);
		wait_idle();
		set_reg(REG_GAIN_ORIGINAL, 1023);
		set_reg(REG_GAIN_BLURRED, 0);
		set_reg(REG_FRAME_WIDTH, 2);
		set_reg(REG_FRAME_HEIGHT, 1);
		send_item(8'hFF, 1'b0);
		send_item(8'h80, 1'b0);
		send_item(8'h00, 1'b1);
		send_item(8'h33, 1'b1);
		wait_idle();
		set_reg(REG_GAIN_ORIGINAL, 0);
		set_reg(REG_GAIN_BLURRED, 1023);
		set_reg(REG_FRAME_WIDTH, 1);
		set_reg(REG_FRAME_HEIGHT, 2);
		send_item(8'hC8, 1'b0);
		send_item(8'hFF, 1'b0);
		send_item(8'h01, 1'b1);
	endtask

	task automatic test_random_frames();
		int frame_no;
		int roll;
		int stop_at;
		frame_no = 0;
		stop_at = item_count + RANDOM_ITEMS;
		while (item_count < stop_at) begin
			wait_idle();
			if (frame_no == 3) begin
				set_reg(REG_FRAME_WIDTH, 511);
				set_reg(REG_FRAME_HEIGHT, 1);
			end else if (frame_no == 8) begin
				set_reg(REG_FRAME_WIDTH, 2);
				set_reg(REG_FRAME_HEIGHT, 256);
			end else begin
				set_reg(REG_FRAME_WIDTH, $urandom_range(0, 16));
				set_reg(REG_FRAME_HEIGHT, $urandom_range(0, 8));
			end
			roll = $urandom_range(0, 99);
			if (roll < 15) begin
				set_reg(REG_GAIN_ORIGINAL, $urandom_range(0, 1) ? 1023 : 0);
				set_reg(REG_GAIN_BLURRED, $urandom_range(0, 1) ? 1023 : 0);
			end else if (roll < 35) begin
				set_reg(REG_GAIN_ORIGINAL, 32'(GAIN_ORIGINAL_RST));
				set_reg(REG_GAIN_BLURRED, 32'(GAIN_BLURRED_RST));
			end else begin
				set_reg(REG_GAIN_ORIGINAL, $urandom_range(0, 1023));
				set_reg(REG_GAIN_BLURRED, $urandom_range(0, 1023));
			end
			steady = ($urandom_range(0, 4) == 0);
			send_frame(5);
			steady = 1'b0;
			frame_no++;
		end
	endtask

	// Output side: random back-pressure, with stretches of none.
	always @(negedge clk) begin
		if (stall_left > 0) begin
			m_axis_tready <= 1'b0;
			stall_left = stall_left - 1;
		end else begin
			m_axis_tready <= 1'b1;
			stall_left = pick_gap();
		end
	end

	always @(posedge clk) begin : check_out
		crisp_pix_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (crisp_q.size() == 0) begin
				report_mismatch("unexpected output beat, pixel_out", -1, int'(m_axis_tdata));
			end else begin
				want = crisp_q.pop_front();
				if (m_axis_tdata !== want.pix)
					report_mismatch("pixel_out", int'(want.pix), int'(m_axis_tdata));
				if (m_axis_tlast !== want.row_end)
					report_mismatch("row_last", int'(want.row_end), int'(m_axis_tlast));
				if (m_axis_tuser !== want.frame_end)
					report_mismatch("frame_last", int'(want.frame_end), int'(m_axis_tuser));
			end
		end
	end

	initial begin
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("Regression FAIL");
		$finish;
	end

	initial begin
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_defaults_and_shrink();
		test_corner_sizes();
		test_random_frames();
		wait_idle();
		if (err_count == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
